// ===== rtl/scit_pkg.sv =====
// ----------------------------------------------------------------------------
// scit_pkg
// Shared types and constants for the segment / circle intersection test.
// ----------------------------------------------------------------------------
package scit_pkg;

    // look-ahead radius register: unsigned, same fraction bits as coordinates
    localparam int RADIUS_WIDTH = 23;

    typedef logic [RADIUS_WIDTH-1:0] t_radius;

    localparam t_radius RADIUS_RESET = t_radius'(2560);

endpackage

// ===== rtl/scit_front.sv =====
// ----------------------------------------------------------------------------
// scit_front
// Input stage: takes a segment beat, moves it to robot-relative coordinates,
// flags a zero-length segment and holds the result for the queue.
// ----------------------------------------------------------------------------
module scit_front #(
    parameter int COORD_WIDTH = 24,
    parameter int EW          = 4 * (COORD_WIDTH + 1) + 1
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic signed [COORD_WIDTH-1:0] i_seg_start_x,
    input  logic signed [COORD_WIDTH-1:0] i_seg_end_x,
    input  logic signed [COORD_WIDTH-1:0] i_seg_start_y,
    input  logic signed [COORD_WIDTH-1:0] i_seg_end_y,
    input  logic signed [COORD_WIDTH-1:0] i_robot_x,
    input  logic signed [COORD_WIDTH-1:0] i_robot_y,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [EW-1:0]                 o_data
);
    localparam int DW = COORD_WIDTH + 1;

    logic              r_valid;
    logic [EW-1:0]     r_data;
    logic signed [DW-1:0] w_ax, w_ay, w_dx, w_dy;
    logic              w_zero;
    logic [EW-1:0]     n_data;

    // robot-relative start point and direction
    always_comb begin
        w_ax   = DW'(i_seg_start_x) - DW'(i_robot_x);
        w_ay   = DW'(i_seg_start_y) - DW'(i_robot_y);
        w_dx   = DW'(i_seg_end_x) - DW'(i_seg_start_x);
        w_dy   = DW'(i_seg_end_y) - DW'(i_seg_start_y);
        w_zero = (i_seg_end_x == i_seg_start_x) && (i_seg_end_y == i_seg_start_y);
        n_data = {w_zero, w_ax, w_ay, w_dx, w_dy};
    end

    assign o_stall = r_valid && i_stall;
    assign o_valid = r_valid;
    assign o_data  = r_data;

    // holding register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (!o_stall) begin
            r_valid <= i_valid;
        end
        if (i_valid && !o_stall) begin
            r_data <= n_data;
        end
    end

endmodule

// ===== rtl/scit_queue.sv =====
// ----------------------------------------------------------------------------
// scit_queue
// Small FIFO between front and back so each side stalls on its own.
// ----------------------------------------------------------------------------
module scit_queue #(
    parameter int EW = 101
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_stall,
    input  logic [EW-1:0] i_data,
    output logic          o_valid,
    input  logic          i_stall,
    output logic [EW-1:0] o_data
);
    localparam int DEPTH = 4;
    localparam int AW    = $clog2(DEPTH);

    logic [EW-1:0] r_mem [DEPTH];
    logic [AW-1:0] r_wr_ptr, r_rd_ptr;
    logic [AW:0]   r_cnt;
    logic          w_push, w_pop;

    assign o_stall = (r_cnt == (AW+1)'(DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign w_push  = i_valid && !o_stall;
    assign w_pop   = o_valid && !i_stall;

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            if (w_push) r_wr_ptr <= r_wr_ptr + 1'b1;
            if (w_pop)  r_rd_ptr <= r_rd_ptr + 1'b1;
            if (w_push && !w_pop)      r_cnt <= r_cnt + 1'b1;
            else if (w_pop && !w_push) r_cnt <= r_cnt - 1'b1;
        end
    end

    // storage
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

// ===== rtl/scit_back.sv =====
// ----------------------------------------------------------------------------
// scit_back
// Five-stage evaluation pipeline: quadratic coefficients a, b, c, end-point
// signs, and an exact split-multiply discriminant check for the vertex case.
// ----------------------------------------------------------------------------
module scit_back
    import scit_pkg::*;
#(
    parameter int COORD_WIDTH = 24,
    parameter int EW          = 4 * (COORD_WIDTH + 1) + 1
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_stall,
    input  logic [EW-1:0] i_data,
    input  t_radius       i_radius,
    output logic          o_valid,
    input  logic          i_stall,
    output logic          o_hit
);
    localparam int DW   = COORD_WIDTH + 1;
    localparam int PW0  = 2 * DW;
    localparam int RW2  = 2 * RADIUS_WIDTH;
    localparam int CWD  = ((2 * DW + 1) > RW2 ? (2 * DW + 1) : RW2) + 1;
    localparam int FW   = CWD + 2;
    localparam int H    = (CWD + 1) / 2;
    localparam int LW   = 2 * H;
    localparam int PW   = 2 * LW;
    localparam int NS   = 5;

    // handshake chain
    logic [NS-1:0] r_v;
    logic [NS-1:0] w_rdy;

    always_comb begin
        w_rdy[NS-1] = !r_v[NS-1] || !i_stall;
        for (int k = NS - 2; k >= 0; k--) begin
            w_rdy[k] = !r_v[k] || w_rdy[k+1];
        end
    end

    assign o_stall = !w_rdy[0];
    assign o_valid = r_v[NS-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (w_rdy[0]) r_v[0] <= i_valid;
            for (int k = 1; k < NS; k++) begin
                if (w_rdy[k]) r_v[k] <= r_v[k-1];
            end
        end
    end

    // stage 0: products of the differences
    logic signed [DW-1:0]  w_ax, w_ay, w_dx, w_dy;
    logic                  w_zero;
    logic signed [PW0-1:0] r_dxdx, r_dydy, r_axdx, r_aydy, r_axax, r_ayay;
    logic [RW2-1:0]        r_rr;
    logic                  r_zero0;

    assign {w_zero, w_ax, w_ay, w_dx, w_dy} = i_data;

    always_ff @(posedge i_clk) begin
        if (w_rdy[0]) begin
            r_dxdx  <= w_dx * w_dx;
            r_dydy  <= w_dy * w_dy;
            r_axdx  <= w_ax * w_dx;
            r_aydy  <= w_ay * w_dy;
            r_axax  <= w_ax * w_ax;
            r_ayay  <= w_ay * w_ay;
            r_rr    <= RW2'(i_radius) * RW2'(i_radius);
            r_zero0 <= w_zero;
        end
    end

    // stage 1: coefficients a, b, -b, c
    logic signed [CWD-1:0] r_a, r_b, r_bn, r_c;
    logic                  r_zero1;

    always_ff @(posedge i_clk) begin
        if (w_rdy[1]) begin
            r_a     <= CWD'(r_dxdx) + CWD'(r_dydy);
            r_b     <= CWD'(r_axdx) + CWD'(r_aydy);
            r_bn    <= -CWD'(r_axdx) - CWD'(r_aydy);
            r_c     <= CWD'(r_axax) + CWD'(r_ayay) - CWD'($signed({1'b0, r_rr}));
            r_zero1 <= r_zero0;
        end
    end

    // stage 2: end-point signs and partial products of b^2 and a*c
    logic signed [FW-1:0] w_f1, w_ab;
    logic                 w_c_neg, w_c_zero, w_f_neg, w_f_zero, w_early, w_miss;
    logic [LW-1:0]        w_am, w_bm, w_cm;
    logic                 r_known, r_val;
    logic [LW-1:0]        r_bb_hh, r_bb_hl, r_bb_ll;
    logic [LW-1:0]        r_ac_hh, r_ac_hl, r_ac_lh, r_ac_ll;

    always_comb begin
        w_f1     = FW'(r_a) + FW'(r_b) + FW'(r_b) + FW'(r_c);
        w_ab     = FW'(r_a) + FW'(r_b);
        w_c_neg  = r_c[CWD-1];
        w_c_zero = (r_c == '0);
        w_f_neg  = w_f1[FW-1];
        w_f_zero = (w_f1 == '0);
        // root at an end of [0,1] or a sign change across it
        w_early  = ((w_c_neg || w_c_zero) && !w_f_neg) ||
                   (!w_c_neg && (w_f_neg || w_f_zero));
        // both ends inside, or vertex outside [0,1]
        w_miss   = w_c_neg || r_bn[CWD-1] || w_ab[FW-1];
        w_am     = LW'($unsigned(r_a));
        w_bm     = LW'($unsigned(r_bn));
        w_cm     = LW'($unsigned(r_c));
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy[2]) begin
            r_known <= r_zero1 || w_early || w_miss;
            r_val   <= !r_zero1 && w_early;
            r_bb_hh <= w_bm[LW-1:H] * w_bm[LW-1:H];
            r_bb_hl <= w_bm[LW-1:H] * w_bm[H-1:0];
            r_bb_ll <= w_bm[H-1:0] * w_bm[H-1:0];
            r_ac_hh <= w_am[LW-1:H] * w_cm[LW-1:H];
            r_ac_hl <= w_am[LW-1:H] * w_cm[H-1:0];
            r_ac_lh <= w_am[H-1:0] * w_cm[LW-1:H];
            r_ac_ll <= w_am[H-1:0] * w_cm[H-1:0];
        end
    end

    // stage 3: recombine partial products
    logic [PW-1:0] r_bb, r_ac;
    logic          r_known3, r_val3;

    always_ff @(posedge i_clk) begin
        if (w_rdy[3]) begin
            r_bb     <= {r_bb_hh, r_bb_ll} + (PW'(r_bb_hl) << (H + 1));
            r_ac     <= {r_ac_hh, r_ac_ll} + ((PW'(r_ac_hl) + PW'(r_ac_lh)) << H);
            r_known3 <= r_known;
            r_val3   <= r_val;
        end
    end

    // stage 4: output register, discriminant sign for the vertex case
    logic r_hit;

    always_ff @(posedge i_clk) begin
        if (w_rdy[4]) begin
            r_hit <= r_known3 ? r_val3 : (r_bb >= r_ac);
        end
    end

    assign o_hit = r_hit;

endmodule

// ===== rtl/segment_circle_intersection_test.sv =====
// ----------------------------------------------------------------------------
// segment_circle_intersection_test
// Reports whether a segment meets the look-ahead circle around the robot.
// ----------------------------------------------------------------------------
// Accepts one segment per clock while o_stall is low and returns one hit
// beat per segment, in order. Path: front register, queue, five evaluation
// stages; throughput is one beat per cycle while i_stall is low, set by
// the fully pipelined evaluation path. A four-deep queue between front and
// back absorbs downstream stalls. The test is exact: end-point signs of the
// quadratic along the segment, plus an exact b^2 >= a*c check from split
// multiplies when the nearest point lies between both outside ends.
// Coordinates and radius share one fixed-point scale, so the fraction bit
// count does not affect the logic. Write the radius only while idle.
// ----------------------------------------------------------------------------
module segment_circle_intersection_test
    import scit_pkg::*;
#(
    parameter int COORD_WIDTH = 24
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [RADIUS_WIDTH-1:0]       i_cfg_wdata,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic signed [COORD_WIDTH-1:0] i_seg_start_x,
    input  logic signed [COORD_WIDTH-1:0] i_seg_end_x,
    input  logic signed [COORD_WIDTH-1:0] i_seg_start_y,
    input  logic signed [COORD_WIDTH-1:0] i_seg_end_y,
    input  logic signed [COORD_WIDTH-1:0] i_robot_x,
    input  logic signed [COORD_WIDTH-1:0] i_robot_y,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic                          o_hit
);
    localparam int EW = 4 * (COORD_WIDTH + 1) + 1;

    // radius register
    t_radius r_radius;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radius <= RADIUS_RESET;
        end else if (i_cfg_we) begin
            r_radius <= i_cfg_wdata;
        end
    end

    logic          w_f_valid, w_f_stall;
    logic [EW-1:0] w_f_data;
    logic          w_q_valid, w_q_stall;
    logic [EW-1:0] w_q_data;

    scit_front #(.COORD_WIDTH(COORD_WIDTH), .EW(EW)) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_seg_start_x (i_seg_start_x),
        .i_seg_end_x   (i_seg_end_x),
        .i_seg_start_y (i_seg_start_y),
        .i_seg_end_y   (i_seg_end_y),
        .i_robot_x     (i_robot_x),
        .i_robot_y     (i_robot_y),
        .o_valid       (w_f_valid),
        .i_stall       (w_f_stall),
        .o_data        (w_f_data)
    );

    scit_queue #(.EW(EW)) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_f_valid),
        .o_stall (w_f_stall),
        .i_data  (w_f_data),
        .o_valid (w_q_valid),
        .i_stall (w_q_stall),
        .o_data  (w_q_data)
    );

    scit_back #(.COORD_WIDTH(COORD_WIDTH), .EW(EW)) u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (w_q_valid),
        .o_stall  (w_q_stall),
        .i_data   (w_q_data),
        .i_radius (r_radius),
        .o_valid  (o_valid),
        .i_stall  (i_stall),
        .o_hit    (o_hit)
    );

    // front only stalls when it holds a beat the full queue cannot take
    a_front_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (w_f_valid && w_f_stall))
        else $error("front stalled without a blocked beat");

    // a beat pushed into the queue leaves it non-empty
    a_queue_push: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_f_valid && !w_f_stall) |=> w_q_valid)
        else $error("queue empty after push");

    // a full queue always presents a valid beat to the back end
    a_queue_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_f_stall |-> w_q_valid)
        else $error("queue full but reports empty");

endmodule
